// File: hdl/pbrp_pkg.sv
package pbrp_pkg;

  localparam int unsigned SegWidth = 13;
  localparam logic [SegWidth-1:0] MaxSegment = 13'd4096;
  localparam logic [SegWidth-1:0] SegmentReset = 13'd128;

  // The control byte that carries no run.
  localparam logic [7:0] SkipByte = 8'h80;

  // Register word indexes on the configuration port.
  localparam logic RegSegmentPixels = 1'b0;
  localparam logic RegWideSamples   = 1'b1;

  typedef enum logic [1:0] {
    PH_CONTROL = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_RUN     = 2'd0,
    KIND_SAMPLE  = 2'd1,
    KIND_OVERRUN = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  length_code;
    logic [15:0] sample;
    logic        segment_end;
  } result_t;

endpackage

// File: hdl/pbrp_decode.sv
module pbrp_decode
  import pbrp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                restart_i,
  input  logic [SegWidth-1:0] segment_pixels_i,
  input  logic                wide_samples_i,
  input  logic                in_fire_i,
  input  logic [7:0]          in_byte_i,
  output logic                res_valid_o,
  output result_t             res_o
);

  phase_e              phase_q, phase_d;
  logic [7:0]          samples_left_q, samples_left_d;
  logic [SegWidth-1:0] pixels_done_q, pixels_done_d;
  logic [7:0]          low_byte_hold_q, low_byte_hold_d;
  logic                byte_half_q, byte_half_d;
  logic                run_is_last_q, run_is_last_d;

  logic [SegWidth-1:0] limit;
  logic [7:0]          run_len;
  logic [7:0]          neg_byte;
  logic [7:0]          run_code;
  logic [SegWidth:0]   pixels_sum;
  logic                overrun;
  logic [7:0]          left_dec;
  logic                hold_low;

  assign limit    = (segment_pixels_i > MaxSegment) ? MaxSegment : segment_pixels_i;
  assign neg_byte = 8'd0 - in_byte_i;
  // A literal run has byte+1 samples; a repeat run repeats one sample 257-byte times.
  assign run_len  = in_byte_i[7] ? 8'(9'd257 - {1'b0, in_byte_i})
                                 : ({1'b0, in_byte_i[6:0]} + 8'd1);
  assign run_code = in_byte_i[7] ? {neg_byte[6:0], 1'b1} : {in_byte_i[6:0], 1'b0};
  assign pixels_sum = {1'b0, pixels_done_q} + {{(SegWidth-7){1'b0}}, run_len};
  assign overrun    = pixels_sum > {1'b0, limit};
  assign left_dec   = (samples_left_q == 8'd0) ? 8'd0 : samples_left_q - 8'd1;
  // In 16-bit mode the first byte of each sample is only held.
  assign hold_low   = wide_samples_i && !byte_half_q;

  always_comb begin
    phase_d         = phase_q;
    samples_left_d  = samples_left_q;
    pixels_done_d   = pixels_done_q;
    low_byte_hold_d = low_byte_hold_q;
    byte_half_d     = byte_half_q;
    run_is_last_d   = run_is_last_q;
    if (restart_i) begin
      phase_d         = PH_CONTROL;
      samples_left_d  = '0;
      pixels_done_d   = '0;
      low_byte_hold_d = '0;
      byte_half_d     = 1'b0;
      run_is_last_d   = 1'b0;
    end else if (in_fire_i) begin
      unique case (phase_q)
        PH_CONTROL: begin
          if (in_byte_i != SkipByte && !overrun) begin
            pixels_done_d  = pixels_sum[SegWidth-1:0];
            run_is_last_d  = (pixels_sum[SegWidth-1:0] == limit);
            phase_d        = in_byte_i[7] ? PH_REPEAT : PH_LITERAL;
            samples_left_d = in_byte_i[7] ? 8'd1 : run_len;
            byte_half_d    = 1'b0;
          end
        end
        PH_LITERAL, PH_REPEAT: begin
          if (hold_low) begin
            low_byte_hold_d = in_byte_i;
            byte_half_d     = 1'b1;
          end else begin
            byte_half_d    = 1'b0;
            samples_left_d = left_dec;
            if (left_dec == 8'd0) begin
              phase_d       = PH_CONTROL;
              run_is_last_d = 1'b0;
              if (run_is_last_q) begin
                pixels_done_d = '0;
              end
            end
          end
        end
        default: begin
          phase_d = PH_CONTROL;
        end
      endcase
    end
  end

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (in_fire_i && !restart_i) begin
      unique case (phase_q)
        PH_CONTROL: begin
          if (in_byte_i != SkipByte) begin
            res_valid_o = 1'b1;
            if (overrun) begin
              res_o.kind = KIND_OVERRUN;
            end else begin
              res_o.kind        = KIND_RUN;
              res_o.length_code = run_code;
            end
          end
        end
        PH_LITERAL, PH_REPEAT: begin
          if (!hold_low) begin
            res_valid_o       = 1'b1;
            res_o.kind        = KIND_SAMPLE;
            res_o.sample      = wide_samples_i ? {in_byte_i, low_byte_hold_q}
                                               : {8'd0, in_byte_i};
            res_o.segment_end = (left_dec == 8'd0) && run_is_last_q;
          end
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_CONTROL;
      samples_left_q  <= '0;
      pixels_done_q   <= '0;
      low_byte_hold_q <= '0;
      byte_half_q     <= 1'b0;
      run_is_last_q   <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      samples_left_q  <= samples_left_d;
      pixels_done_q   <= pixels_done_d;
      low_byte_hold_q <= low_byte_hold_d;
      byte_half_q     <= byte_half_d;
      run_is_last_q   <= run_is_last_d;
    end
  end

  // Between runs no samples may remain outstanding.
  a_control_no_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CONTROL |-> samples_left_q == 8'd0)
    else $error("samples left over while expecting a control byte");

  // A held low byte only exists inside a run of 16-bit samples.
  a_half_in_wide_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_half_q |-> (wide_samples_i && phase_q != PH_CONTROL))
    else $error("low byte held outside a 16-bit run");

  // The pixel count never passes the segment limit.
  a_pixels_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixels_done_q <= limit)
    else $error("pixel count beyond segment limit");

  // The last-run flag is cleared when its run ends.
  a_last_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_is_last_q |-> phase_q != PH_CONTROL)
    else $error("last-run flag set between runs");

endmodule

// File: hdl/pbrp_skid.sv
module pbrp_skid
  import pbrp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    full_o,
  output logic    out_valid_o,
  output result_t out_o,
  input  logic    out_stall_i
);

  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    skid_valid_q, skid_valid_d;
  result_t skid_q, skid_d;
  logic    out_fire;

  assign out_fire = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = res_valid_i;
        out_d       = res_i;
      end
    end else if (res_valid_i) begin
      // The output register is stalled, so the new result waits in the skid entry.
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The skid entry is only used behind a waiting output.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // No result may arrive while the skid entry is occupied.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> !skid_valid_q)
    else $error("result lost on full buffer");

  // A stalled output with a waiting result keeps the skid entry filled.
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("skid entry dropped while output stalled");

endmodule

// File: hdl/packbits_run_record_parser.sv
// PackBits run record parser.
// Input channel: one coded byte per transaction on in_byte_i, qualified by
// in_valid_i and held off by in_stall_o. Output channel: one result per
// transaction (kind_o, length_code_o, sample_o, segment_end_o) qualified by
// out_valid_o and held off by out_stall_i. A control byte yields a run
// record or an overrun error, each sample yields a sample value, and the
// skip byte and the low byte of a 16-bit sample yield nothing.
// A result is registered in the output register, or in the skid register
// if the output is stalled. Throughput is one byte every cycle unless
// in_stall_o is high; the parser state updates as the byte is accepted.
// Configuration is written through the APB-style port (segment_pixels at
// address 0, wide_samples at address 4) while the block is idle; any write
// restarts the parser. Reset sets 128-sample segments with 8-bit samples and
// an empty parser waiting for a control byte.
// When the receiver stalls, one more result is caught in a skid register;
// in_stall_o rises only once that register is full, and the held results
// leave in order when the stall drops.
module packbits_run_record_parser
  import pbrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  length_code_o,
  output logic [15:0] sample_o,
  output logic        segment_end_o
);

  logic [SegWidth-1:0] segment_pixels_q;
  logic                wide_samples_q;
  logic                cfg_write;
  logic                in_fire;
  logic                skid_full;
  logic                res_valid;
  result_t             res;
  result_t             out_res;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segment_pixels_q <= SegmentReset;
      wide_samples_q   <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        RegSegmentPixels: segment_pixels_q <= pwdata[SegWidth-1:0];
        RegWideSamples:   wide_samples_q   <= pwdata[0];
        default:          wide_samples_q   <= wide_samples_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegSegmentPixels: prdata = {{(32-SegWidth){1'b0}}, segment_pixels_q};
      RegWideSamples:   prdata = {31'd0, wide_samples_q};
      default:          prdata = '0;
    endcase
  end

  assign in_stall_o = skid_full;
  assign in_fire    = in_valid_i && !skid_full;

  pbrp_decode u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .restart_i        (cfg_write),
    .segment_pixels_i (segment_pixels_q),
    .wide_samples_i   (wide_samples_q),
    .in_fire_i        (in_fire),
    .in_byte_i        (in_byte_i),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  pbrp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_o       (out_res),
    .out_stall_i (out_stall_i)
  );

  assign kind_o        = out_res.kind;
  assign length_code_o = out_res.length_code;
  assign sample_o      = out_res.sample;
  assign segment_end_o = out_res.segment_end;

endmodule
